// ===== src/assert_macros.svh =====
// Assertion macros for the row noise adder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== src/rsna_pkg.sv =====
// Shared types and constants for the row noise adder
package rsna_pkg;
	localparam int MaxRowLength = 64;
	localparam int AddrW = $clog2(MaxRowLength);
	localparam int CntW = $clog2(MaxRowLength + 1);

	typedef struct packed {
		logic signed [31:0] sample_value;
		logic signed [15:0] noise_sample;
		logic end_of_row;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] out_value;
		logic last_of_row;
		logic saturated;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic wr_en;        // store accepted item
		logic rd_en;        // issue buffer read at rd_addr
		logic [AddrW-1:0] rd_addr;
		logic mean_start;   // start sum / n
		logic sq_acc;       // accumulate (x-mean)^2 of read data
		logic sq_clr;
		logic var_start;    // start variance divide
		logic sqrt_start;
		logic scale_load;   // std * gain
		logic mul_s1;       // output pipeline stage 1 load
		logic out_load;     // output register load
		logic out_last;
		logic row_clr;
	} dp_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic sqrt_busy;
	} dp_sts_t;
endpackage

// ===== src/row_std_scaled_noise_adder.sv =====
// Row noise adder top level: controller, datapath and assertions
// Samples are buffered until a row closes (end_of_row or 64 elements). Then
// the row mean is found with a serial divider, a second read pass sums
// squared deviations, the variance takes another divide and the standard
// deviation a square root. Results then stream out one at a time, and the
// next row is not taken until the last result of this one has been accepted;
// inputs are taken only while the block is filling a row.
module row_std_scaled_noise_adder
	import rsna_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_item_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_item_t out_data,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [15:0] cfg_data
);
`include "assert_macros.svh"
	logic [15:0] gain_q;
	dp_cmd_t cmd;
	dp_sts_t sts;
	logic [AddrW-1:0] wr_addr;
	logic [CntW-1:0] row_len;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) gain_q <= 16'd256;
		else if (cfg_valid) gain_q <= cfg_data;
	end

	rsna_ctrl u_ctrl (.clk, .arst_n, .in_valid, .in_ready,
		.in_eor(in_data.end_of_row), .out_valid, .out_ready, .sts, .cmd,
		.wr_addr, .row_len);
	rsna_datapath u_dp (.clk, .arst_n, .cmd, .sts, .in_item(in_data), .wr_addr,
		.row_len, .gain(gain_q), .out_item(out_data));

	`ASSERT_NEVER(a_in_while_out, clk, arst_n, in_ready && out_valid)
	`ASSERT_NEVER(a_len_range, clk, arst_n, row_len > CntW'(MaxRowLength))
	`ASSERT_IMPL(a_hold, clk, arst_n, out_valid && !out_ready |=> out_valid)
endmodule

// ===== src/rsna_ram.sv =====
// Generic single-port-write, registered-read RAM
module rsna_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end
endmodule

// ===== src/rsna_div.sv =====
// Restoring divider: 72-bit dividend by 7-bit divisor, one quotient bit a cycle
module rsna_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [71:0] dividend,
	input  logic [6:0] divisor,
	output logic busy,
	output logic [71:0] quot,
	output logic [7:0] rem
);
	logic [6:0] cnt_q;
	logic [7:0] rem_q;
	logic [71:0] quot_q;
	logic [7:0] trial;
	logic [8:0] diff;
	assign trial = {rem_q[6:0], quot_q[71]};
	assign diff = {1'b0, trial} - {2'b0, divisor};
	assign quot = quot_q;
	assign rem = rem_q;
	assign busy = (cnt_q != '0);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 7'd72;
		end else if (busy) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quot_q <= dividend;
		end else if (busy) begin
			if (!diff[8]) begin
				rem_q <= diff[7:0];
				quot_q <= {quot_q[70:0], 1'b1};
			end else begin
				rem_q <= trial;
				quot_q <= {quot_q[70:0], 1'b0};
			end
		end
	end
endmodule

// ===== src/rsna_sqrt.sv =====
// Bit-pair integer square root of a 64-bit value, one result bit a cycle
module rsna_sqrt (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [63:0] radicand,
	output logic busy,
	output logic [31:0] root
);
	logic [5:0] cnt_q;
	logic [63:0] val_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [33:0] trial, sub;
	assign busy = (cnt_q != '0);
	assign root = root_q;
	assign trial = {rem_q[31:0], val_q[63:62]};
	assign sub = trial - {root_q, 2'b01};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'd32;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= radicand;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy) begin
			val_q <= {val_q[61:0], 2'b00};
			if (trial >= {root_q, 2'b01}) begin
				rem_q <= sub;
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q <= trial;
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end
endmodule

// ===== src/rsna_datapath.sv =====
// Buffers, statistics and output arithmetic of the row noise adder
module rsna_datapath
	import rsna_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  dp_cmd_t cmd,
	output dp_sts_t sts,
	input  in_item_t in_item,
	input  logic [AddrW-1:0] wr_addr,
	input  logic [CntW-1:0] row_len,
	input  logic [15:0] gain,
	output out_item_t out_item
);
	logic [31:0] smp_rd;
	logic [15:0] nz_rd;
	logic signed [37:0] sum_q;
	logic signed [32:0] mean_q;
	logic [70:0] sq_q;
	logic [15:0] gain_q;
	logic [47:0] scale_q;
	logic [71:0] div_in;
	logic [71:0] quot;
	logic [7:0] div_rem;
	logic div_start;
	logic div_busy, sqrt_busy;
	logic [31:0] root;
	logic [71:0] sum_mag;

	rsna_ram #(.Width(32), .Depth(MaxRowLength)) u_smp (
		.clk, .we(cmd.wr_en), .waddr(wr_addr), .wdata(in_item.sample_value),
		.re(cmd.rd_en), .raddr(cmd.rd_addr), .rdata(smp_rd));
	rsna_ram #(.Width(16), .Depth(MaxRowLength)) u_nz (
		.clk, .we(cmd.wr_en), .waddr(wr_addr), .wdata(in_item.noise_sample),
		.re(cmd.rd_en), .raddr(cmd.rd_addr), .rdata(nz_rd));

	// floor division of a signed sum: divide magnitude, fix sign afterwards
	assign sum_mag = sum_q[37] ? -72'(sum_q) : 72'(sum_q);
	assign div_in = cmd.var_start ? {1'b0, sq_q} : sum_mag;
	assign div_start = cmd.mean_start | cmd.var_start;

	rsna_div u_div (.clk, .arst_n, .start(div_start), .dividend(div_in),
		.divisor(row_len), .busy(div_busy), .quot(quot), .rem(div_rem));
	rsna_sqrt u_sqrt (.clk, .arst_n, .start(cmd.sqrt_start), .radicand(quot[63:0]),
		.busy(sqrt_busy), .root(root));

	assign sts.div_busy = div_busy;
	assign sts.sqrt_busy = sqrt_busy;

	// mean fixup: a nonzero remainder pushes a negative quotient down by one
	logic signed [32:0] mean_pos, mean_neg;
	assign mean_pos = quot[32:0];
	assign mean_neg = (div_rem != '0) ? -quot[32:0] - 33'sd1 : -quot[32:0];

	logic signed [33:0] d;
	logic [32:0] dmag;
	logic [65:0] d2;
	assign d = 34'($signed(smp_rd)) - 34'(mean_q);
	assign dmag = d[33] ? 33'(-d) : 33'(d);
	assign d2 = dmag * dmag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else begin
			if (cmd.row_clr) sum_q <= '0;
			else if (cmd.wr_en) sum_q <= sum_q + 38'(in_item.sample_value);
		end
	end

	// mean is latched once its division finishes (first sq_clr)
	logic nz_neg_s1;
	logic [63:0] prod_s1;
	logic signed [31:0] x_s1;
	logic last_s1;
	logic [15:0] nmag;
	logic [44:0] t;
	logic signed [45:0] tot;
	assign nmag = nz_rd[15] ? 16'(-$signed(nz_rd)) : nz_rd;
	assign t = 45'((prod_s1 + 64'd524288) >> 20);
	assign tot = 46'(x_s1) + (nz_neg_s1 ? -46'(t) : 46'(t));

	always_ff @(posedge clk) begin
		if (cmd.sq_clr) begin
			sq_q <= '0;
			mean_q <= sum_q[37] ? mean_neg : mean_pos;
			gain_q <= gain;
		end else if (cmd.sq_acc) begin
			sq_q <= sq_q + 71'(d2);
		end
		if (cmd.scale_load) begin
			scale_q <= root * gain_q;
		end
		if (cmd.mul_s1) begin
			prod_s1 <= 64'(nmag) * scale_q[47:0];
			nz_neg_s1 <= nz_rd[15];
			x_s1 <= smp_rd;
			last_s1 <= cmd.out_last;
		end
		if (cmd.out_load) begin
			out_item.last_of_row <= last_s1;
			if (tot > 46'sh7FFFFFFF) begin
				out_item.out_value <= 32'sh7FFFFFFF;
				out_item.saturated <= 1'b1;
			end else if (tot < -46'sh80000000) begin
				out_item.out_value <= 32'sh80000000;
				out_item.saturated <= 1'b1;
			end else begin
				out_item.out_value <= tot[31:0];
				out_item.saturated <= 1'b0;
			end
		end
	end
endmodule

// ===== src/rsna_ctrl.sv =====
// Sequencer: fill, mean, variance pass, root, scale, output pass, drain
module rsna_ctrl
	import rsna_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic in_eor,
	output logic out_valid,
	input  logic out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd,
	output logic [AddrW-1:0] wr_addr,
	output logic [CntW-1:0] row_len
);
	typedef enum logic [7:0] {
		S_FILL = 8'b0000_0001, S_MEAN = 8'b0000_0010, S_SQ = 8'b0000_0100,
		S_VAR = 8'b0000_1000, S_ROOT = 8'b0001_0000, S_SCL = 8'b0010_0000,
		S_OUT = 8'b0100_0000, S_WAIT = 8'b1000_0000
	} state_t;
	state_t state_q;
	logic [CntW-1:0] cnt_q, idx_q;
	logic started_q;
	logic [1:0] pipe_q; // [0]: read issued, [1]: s1 loaded
	logic out_valid_q;
	logic acc;
	logic s1_free;

	assign row_len = cnt_q;
	assign wr_addr = cnt_q[AddrW-1:0];
	assign in_ready = (state_q == S_FILL);
	assign acc = in_valid && in_ready;
	assign out_valid = out_valid_q;
	// output stage advances when the output register is empty or taken
	assign s1_free = !out_valid_q || out_ready;

	always_comb begin
		cmd = '0;
		cmd.wr_en = acc;
		cmd.rd_addr = idx_q[AddrW-1:0];
		cmd.mean_start = (state_q == S_MEAN) && !started_q;
		cmd.sq_clr = (state_q == S_SQ) && !started_q;
		cmd.rd_en = ((state_q == S_SQ) && idx_q < cnt_q)
			|| ((state_q == S_OUT) && idx_q < cnt_q && (s1_free || !pipe_q[1]) && !pipe_q[0]);
		cmd.sq_acc = (state_q == S_SQ) && pipe_q[0];
		cmd.var_start = (state_q == S_VAR) && !started_q;
		cmd.sqrt_start = (state_q == S_ROOT) && !started_q;
		cmd.scale_load = (state_q == S_SCL);
		cmd.mul_s1 = (state_q == S_OUT) && pipe_q[0];
		cmd.out_last = (idx_q == cnt_q);
		cmd.out_load = (state_q == S_OUT) && pipe_q[1] && s1_free;
		cmd.row_clr = (state_q == S_WAIT) && !out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_FILL;
			cnt_q <= '0;
			idx_q <= '0;
			started_q <= 1'b0;
			pipe_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_FILL: begin
					if (acc) begin
						cnt_q <= cnt_q + 1'b1;
						if (in_eor || cnt_q == CntW'(MaxRowLength - 1)) begin
							state_q <= S_MEAN;
							started_q <= 1'b0;
						end
					end
				end
				S_MEAN: begin
					if (started_q && !sts.div_busy) begin
						state_q <= S_SQ;
						started_q <= 1'b0;
						idx_q <= '0;
						pipe_q <= '0;
					end else begin
						started_q <= 1'b1;
					end
				end
				S_SQ: begin
					if (started_q) begin
						pipe_q[0] <= cmd.rd_en;
						if (cmd.rd_en) idx_q <= idx_q + 1'b1;
						if (!cmd.rd_en && !pipe_q[0] && idx_q == cnt_q) begin
							state_q <= S_VAR;
							started_q <= 1'b0;
						end
					end else begin
						started_q <= 1'b1;
					end
				end
				S_VAR: begin
					if (started_q && !sts.div_busy) begin
						state_q <= S_ROOT;
						started_q <= 1'b0;
					end else begin
						started_q <= 1'b1;
					end
				end
				S_ROOT: begin
					started_q <= 1'b1;
					if (started_q && !sts.sqrt_busy) state_q <= S_SCL;
				end
				S_SCL: begin
					state_q <= S_OUT;
					idx_q <= '0;
					pipe_q <= '0;
				end
				S_OUT: begin
					if (cmd.rd_en) idx_q <= idx_q + 1'b1;
					pipe_q[0] <= cmd.rd_en;
					if (cmd.mul_s1) pipe_q[1] <= 1'b1;
					else if (cmd.out_load) pipe_q[1] <= 1'b0;
					if (cmd.out_load && idx_q == cnt_q && !pipe_q[0]) state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (!out_valid_q) begin
						state_q <= S_FILL;
						cnt_q <= '0;
					end
				end
				default: state_q <= S_FILL;
			endcase
		end
	end
endmodule

// ===== dv/row_std_scaled_noise_adder_test.sv =====
// Self-checking test of the row noise adder: random rows, gain settings and handshake gaps
module row_std_scaled_noise_adder_test
	import rsna_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RowMax = MaxRowLength;
	localparam int IdleLimit = 20000;

	// Predicts per-row noisy outputs and checks them in order
	class noise_row_scoreboard;
		logic [15:0] gain;
		logic signed [31:0] samples[RowMax];
		logic signed [15:0] noises[RowMax];
		int count;
		logic signed [37:0] row_sum;
		out_item_t pending[$];
		int errors;
		int rows;

		function void clear();
			gain = 16'd256;
			count = 0;
			row_sum = '0;
			pending.delete();
			errors = 0;
			rows = 0;
		endfunction

		function logic [31:0] root64(logic [63:0] v);
			logic [63:0] res;
			logic [63:0] b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res[31:0];
		endfunction

		function void close_row();
			logic signed [37:0] mean;
			logic signed [38:0] dev;
			logic [70:0] sq_sum;
			logic [63:0] dev_mag;
			logic [63:0] variance;
			logic [31:0] sdev;
			logic [47:0] scale;
			logic [63:0] mag;
			logic [63:0] t;
			logic signed [64:0] total;
			out_item_t r;
			mean = row_sum / count;
			if (row_sum < 0 && (row_sum % count) != 0) mean = mean - 1;
			sq_sum = '0;
			for (int k = 0; k < count; k++) begin
				dev = samples[k] - mean;
				dev_mag = dev < 0 ? -dev : dev;
				sq_sum = sq_sum + dev_mag * dev_mag;
			end
			variance = sq_sum / count;
			sdev = root64(variance);
			scale = sdev * gain;
			for (int k = 0; k < count; k++) begin
				mag = noises[k] < 0 ? -noises[k] : noises[k];
				t = (mag * scale + (64'd1 << 19)) >> 20;
				total = samples[k];
				total = noises[k] < 0 ? total - $signed({1'b0, t}) : total + $signed({1'b0, t});
				r.saturated = 1'b0;
				if (total > 65'sd2147483647) begin
					total = 65'sd2147483647;
					r.saturated = 1'b1;
				end else if (total < -65'sd2147483648) begin
					total = -65'sd2147483648;
					r.saturated = 1'b1;
				end
				r.out_value = total[31:0];
				r.last_of_row = (k + 1 == count);
				pending.push_back(r);
			end
			count = 0;
			row_sum = '0;
			rows++;
		endfunction

		function void note_input(in_item_t it);
			samples[count] = it.sample_value;
			noises[count] = it.noise_sample;
			count++;
			row_sum = row_sum + it.sample_value;
			if (it.end_of_row || count >= RowMax) close_row();
		endfunction

		task report_mismatch(string what, logic [31:0] want, logic [31:0] got);
			errors++;
			$display("MISMATCH %s: expected %h got %h", what, want, got);
		endtask

		task check_result(out_item_t got);
			out_item_t want;
			if (pending.size() == 0) begin
				report_mismatch("result with nothing expected", 0, got.out_value);
				return;
			end
			want = pending.pop_front();
			if (got.out_value !== want.out_value)
				report_mismatch("out_value", want.out_value, got.out_value);
			if (got.last_of_row !== want.last_of_row)
				report_mismatch("last_of_row", want.last_of_row, got.last_of_row);
			if (got.saturated !== want.saturated)
				report_mismatch("saturated", want.saturated, got.saturated);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [15:0] cfg_data = '0;

	noise_row_scoreboard board = new();
	int idle_cycles;
	int results_seen;
	int hold_off;
	bit stim_done;

	always #5 clk = ~clk;

	row_std_scaled_noise_adder u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	function int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 45) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// receiver side; hold_off forces one long stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				board.check_result(out_data);
				results_seen++;
			end
			if (hold_off > 0) begin
				hold_off--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 3) != 0);
			end
		end
	end

	// watchdog: cycles with no transaction on any channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IdleLimit) begin
			$display("Timeout waiting for a transaction");
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// valid stays high after a transaction; callers that go idle drop it
	task automatic send_item(logic signed [31:0] x, logic signed [15:0] nz, logic eor);
		in_item_t it;
		it.sample_value = x;
		it.noise_sample = nz;
		it.end_of_row = eor;
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_input(it);
	endtask

	task automatic send_gap();
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_gain(logic [15:0] g);
		in_valid <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_data <= g;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		board.gain = g;
	endtask

	function logic signed [31:0] rand_sample();
		int p;
		p = $urandom_range(0, 9);
		if (p < 5) return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
		if (p < 8) return $urandom;
		return p == 8 ? 32'sh7fffffff : 32'sh80000000;
	endfunction

	task automatic send_row(int len, bit gapped);
		for (int k = 0; k < len; k++) begin
			send_item(rand_sample(), 16'($urandom), k == len - 1);
			if (gapped) send_gap();
		end
	endtask

	initial begin
		int sent;
		int len;
		board.clear();
		idle_cycles = 0;
		results_seen = 0;
		hold_off = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single element, extremes, all-equal row, full-length row
		send_item(32'sh12345678, 16'sh7fff, 1'b1);
		send_item(32'sh7fffffff, 16'sh7fff, 1'b0);
		send_item(32'sh80000000, 16'sh8000, 1'b1);
		send_item(32'sh7fffffff, 16'sh8000, 1'b0);
		send_item(32'sh80000000, 16'sh7fff, 1'b0);
		send_item(32'sh00000000, 16'sh0000, 1'b1);
		send_item(32'sh00010000, 16'sh1000, 1'b0);
		send_item(32'sh00010000, 16'shf000, 1'b1);
		drain();
		write_gain(16'hffff);
		send_item(32'sh40000000, 16'sh7fff, 1'b0);
		send_item(32'shc0000000, 16'sh8000, 1'b1);
		drain();
		write_gain(16'h0000);
		send_item(32'sh00030000, 16'sh7fff, 1'b0);
		// gain change while the row is still open applies to this row
		write_gain(16'h0200);
		send_item(-32'sh00030000, 16'sh8000, 1'b1);
		// 64 items without end_of_row close the row by themselves
		for (int k = 0; k < RowMax; k++) send_item(rand_sample(), 16'($urandom), 1'b0);
		sent = 12 + RowMax;

		// long receiver stall while rows keep coming
		hold_off = 800;
		send_row(5, 0);
		send_row(3, 0);
		drain();
		sent += 8;

		while (sent < 400) begin
			if ($urandom_range(0, 9) == 0) begin
				drain();
				case ($urandom_range(0, 3))
					0: write_gain(16'h0000);
					1: write_gain(16'hffff);
					default: write_gain(16'($urandom));
				endcase
			end
			len = $urandom_range(0, 19) == 0 ? $urandom_range(20, RowMax) : $urandom_range(1, 8);
			send_row(len, $urandom_range(0, 2) != 0);
			sent += len;
		end
		drain();
		write_gain(16'd256);

		$display("Covered %0d rows, %0d results checked, gain extremes and a forced stall",
			board.rows, results_seen);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule

// ===== row_std_scaled_noise_adder.f =====
+incdir+src
src/rsna_pkg.sv
src/rsna_ram.sv
src/rsna_div.sv
src/rsna_sqrt.sv
src/rsna_datapath.sv
src/rsna_ctrl.sv
src/row_std_scaled_noise_adder.sv
dv/row_std_scaled_noise_adder_test.sv
